/* design/text_terminal_char_buffer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Text terminal character buffer: assertion macros
// Shared assertion macros. Defining NO_ASSERTIONS leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CHAR_BUFFER_UNIT_MACROS_SVH
`define TEXT_TERMINAL_CHAR_BUFFER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold in the same cycle as the condition.
`define TTCB_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// The property must hold in the cycle after the condition.
`define TTCB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define TTCB_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg)
`define TTCB_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

/* design/ttcb_pkg.sv */
// ----------------------------------------------------------------------------
// Text terminal character buffer: package
// Screen geometry, command codes, word types and ring-row helpers.
// ----------------------------------------------------------------------------
package ttcb_pkg;

  // Screen geometry and field widths.
  localparam int COLS    = 32;
  localparam int ROWS    = 64;
  localparam int COL_W   = 5;
  localparam int ROW_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int MODE_W  = 3;
  localparam int COUNT_W = 7;
  localparam int CELLS   = ROWS * COLS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Byte that moves the cursor to the next line instead of being stored.
  localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_PUT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCROLL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic [COL_W-1:0]   target_col;
    logic [ROW_W-1:0]   target_row;
    logic [COUNT_W-1:0] line_count;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } mem_req_t;

  // Physical row that lies offs rows below base in the ring of rows.
  function automatic logic [ROW_W-1:0] ring_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] offs);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Byte address of a cell from its physical row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

/* design/ttcb_ram.sv */
// ----------------------------------------------------------------------------
// Text terminal character buffer: cell memory
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ttcb_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port and read port share one address; reads return old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/ttcb_out_queue.sv */
// ----------------------------------------------------------------------------
// Text terminal character buffer: result queue
// Two-entry output queue: an output register and a skid register behind it.
// ----------------------------------------------------------------------------
module ttcb_out_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ttcb_pkg::rsp_t push_word,
  output logic          full,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ttcb_pkg::rsp_t rsp
);

  logic [1:0]     cnt;
  logic [1:0]     cnt_next;
  ttcb_pkg::rsp_t q0;
  ttcb_pkg::rsp_t q0_next;
  ttcb_pkg::rsp_t q1;
  ttcb_pkg::rsp_t q1_next;
  logic           pop;

  assign pop       = (cnt != 2'd0) && !rsp_stall;
  assign rsp_valid = (cnt != 2'd0);
  assign rsp       = q0;
  assign full      = (cnt == 2'd2);

  // Queue update: the head is always q0.
  always_comb begin
    cnt_next = cnt;
    q0_next  = q0;
    q1_next  = q1;
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          q0_next = push_word;
        end else begin
          q1_next = push_word;
        end
        cnt_next = cnt + 2'd1;
      end
      2'b01: begin
        q0_next  = q1;
        cnt_next = cnt - 2'd1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          q0_next = push_word;
        end else begin
          q0_next = q1;
          q1_next = push_word;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule

/* design/ttcb_ctrl.sv */
// ----------------------------------------------------------------------------
// Text terminal character buffer: command controller
// Cursor and ring state, command decode and the cell-clearing sweep.
// ----------------------------------------------------------------------------
`include "text_terminal_char_buffer_unit_macros.svh"

module ttcb_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  ttcb_pkg::cmd_t                    cmd,
  input  logic                              q_full,
  output logic                              push,
  output ttcb_pkg::rsp_t                    push_word,
  output ttcb_pkg::mem_req_t                mem_req,
  input  logic [ttcb_pkg::CHAR_W-1:0]       rd_data
);

  ttcb_pkg::state_t                 state;
  ttcb_pkg::state_t                 state_next;
  logic [ttcb_pkg::COL_W-1:0]       cur_col;
  logic [ttcb_pkg::COL_W-1:0]       cur_col_next;
  logic [ttcb_pkg::ROW_W-1:0]       cur_row;
  logic [ttcb_pkg::ROW_W-1:0]       cur_row_next;
  logic [ttcb_pkg::ROW_W-1:0]       top;
  logic [ttcb_pkg::ROW_W-1:0]       top_next;
  logic [ttcb_pkg::ROW_W-1:0]       sw_base;
  logic [ttcb_pkg::ROW_W-1:0]       sw_base_next;
  logic [ttcb_pkg::ROW_W-1:0]       sw_row;
  logic [ttcb_pkg::ROW_W-1:0]       sw_row_next;
  logic [ttcb_pkg::COL_W-1:0]       sw_col;
  logic [ttcb_pkg::COL_W-1:0]       sw_col_next;
  logic [ttcb_pkg::ROW_W-1:0]       sw_last;
  logic [ttcb_pkg::ROW_W-1:0]       sw_last_next;
  logic [ttcb_pkg::COL_W-1:0]       tc;
  logic [ttcb_pkg::ROW_W-1:0]       tr;
  logic [ttcb_pkg::ROW_W-1:0]       lc_rows;
  logic                             accept;
  logic                             scr;

  // New words are taken only when idle and the result queue has room.
  assign cmd_stall = (state != ttcb_pkg::ST_IDLE) || q_full;
  assign accept    = cmd_valid && !cmd_stall;
  assign lc_rows   = cmd.line_count[ttcb_pkg::ROW_W-1:0];

  // Saturate the move and read targets to the screen.
  always_comb begin
    tc = cmd.target_col;
    tr = cmd.target_row;
    if (int'(cmd.target_col) > ttcb_pkg::COLS - 1) begin
      tc = ttcb_pkg::COL_W'(ttcb_pkg::COLS - 1);
    end
    if (int'(cmd.target_row) > ttcb_pkg::ROWS - 1) begin
      tr = ttcb_pkg::ROW_W'(ttcb_pkg::ROWS - 1);
    end
  end

  // Next state, memory requests and results.
  always_comb begin
    state_next   = state;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    top_next     = top;
    sw_base_next = sw_base;
    sw_row_next  = sw_row;
    sw_col_next  = sw_col;
    sw_last_next = sw_last;
    mem_req      = '0;
    push         = 1'b0;
    push_word    = '0;
    scr          = 1'b0;
    unique case (state)
      ttcb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd.mode)
            ttcb_pkg::MODE_PUT: begin
              if (cmd.char_code != ttcb_pkg::NEWLINE) begin
                mem_req.we    = 1'b1;
                mem_req.addr  = ttcb_pkg::cell_addr(ttcb_pkg::ring_row(top, cur_row),
                                                    cur_col);
                mem_req.wdata = cmd.char_code;
              end
              if (cmd.char_code == ttcb_pkg::NEWLINE ||
                  int'(cur_col) == ttcb_pkg::COLS - 1) begin
                cur_col_next = '0;
                if (int'(cur_row) == ttcb_pkg::ROWS - 1) begin
                  // Bottom row: blank the old top row and roll by one.
                  scr          = 1'b1;
                  sw_base_next = top;
                  sw_last_next = '0;
                  sw_row_next  = '0;
                  sw_col_next  = '0;
                  top_next     = ttcb_pkg::ring_row(top, ttcb_pkg::ROW_W'(1));
                  state_next   = ttcb_pkg::ST_SWEEP;
                end else begin
                  cur_row_next = cur_row + ttcb_pkg::ROW_W'(1);
                end
              end else begin
                cur_col_next = cur_col + ttcb_pkg::COL_W'(1);
              end
            end
            ttcb_pkg::MODE_MOVE: begin
              cur_col_next = tc;
              cur_row_next = tr;
            end
            ttcb_pkg::MODE_CLEAR: begin
              cur_col_next = '0;
              cur_row_next = '0;
              top_next     = '0;
              sw_base_next = '0;
              sw_last_next = ttcb_pkg::ROW_W'(ttcb_pkg::ROWS - 1);
              sw_row_next  = '0;
              sw_col_next  = '0;
              state_next   = ttcb_pkg::ST_SWEEP;
            end
            ttcb_pkg::MODE_SCROLL: begin
              if (int'(cmd.line_count) >= ttcb_pkg::ROWS) begin
                // A full screen or more blanks everything.
                scr          = 1'b1;
                top_next     = '0;
                sw_base_next = '0;
                sw_last_next = ttcb_pkg::ROW_W'(ttcb_pkg::ROWS - 1);
                sw_row_next  = '0;
                sw_col_next  = '0;
                state_next   = ttcb_pkg::ST_SWEEP;
              end else if (cmd.line_count != '0) begin
                scr          = 1'b1;
                sw_base_next = top;
                sw_last_next = lc_rows - ttcb_pkg::ROW_W'(1);
                sw_row_next  = '0;
                sw_col_next  = '0;
                top_next     = ttcb_pkg::ring_row(top, lc_rows);
                state_next   = ttcb_pkg::ST_SWEEP;
              end
            end
            ttcb_pkg::MODE_READ: begin
              mem_req.addr = ttcb_pkg::cell_addr(ttcb_pkg::ring_row(top, tr), tc);
              state_next   = ttcb_pkg::ST_READ;
            end
            default: begin
            end
          endcase
          // Every command but read reports at once.
          if (cmd.mode != ttcb_pkg::MODE_READ) begin
            push                 = 1'b1;
            push_word.cell_char  = '0;
            push_word.cursor_col = cur_col_next;
            push_word.cursor_row = cur_row_next;
            push_word.scrolled   = scr;
          end
        end
      end
      ttcb_pkg::ST_READ: begin
        push                 = 1'b1;
        push_word.cell_char  = rd_data;
        push_word.cursor_col = cur_col;
        push_word.cursor_row = cur_row;
        push_word.scrolled   = 1'b0;
        state_next           = ttcb_pkg::ST_IDLE;
      end
      ttcb_pkg::ST_SWEEP: begin
        // Blank one cell a cycle over the rows being exposed or cleared.
        mem_req.we    = 1'b1;
        mem_req.addr  = ttcb_pkg::cell_addr(ttcb_pkg::ring_row(sw_base, sw_row), sw_col);
        mem_req.wdata = '0;
        if (int'(sw_col) == ttcb_pkg::COLS - 1) begin
          sw_col_next = '0;
          if (sw_row == sw_last) begin
            state_next = ttcb_pkg::ST_IDLE;
          end else begin
            sw_row_next = sw_row + ttcb_pkg::ROW_W'(1);
          end
        end else begin
          sw_col_next = sw_col + ttcb_pkg::COL_W'(1);
        end
      end
      default: begin
        state_next = ttcb_pkg::ST_IDLE;
      end
    endcase
  end

  // Reset starts a sweep that blanks the whole cell memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ttcb_pkg::ST_SWEEP;
      cur_col <= '0;
      cur_row <= '0;
      top     <= '0;
      sw_base <= '0;
      sw_row  <= '0;
      sw_col  <= '0;
      sw_last <= ttcb_pkg::ROW_W'(ttcb_pkg::ROWS - 1);
    end else begin
      state   <= state_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      top     <= top_next;
      sw_base <= sw_base_next;
      sw_row  <= sw_row_next;
      sw_col  <= sw_col_next;
      sw_last <= sw_last_next;
    end
  end

  `TTCB_ASSERT_IMPLIES(a_sweep_row_range, clk, rst, state == ttcb_pkg::ST_SWEEP, sw_row <= sw_last, "sweep row ran past its last row")
  `TTCB_ASSERT_NEXT(a_read_one_cycle, clk, rst, state == ttcb_pkg::ST_READ, state == ttcb_pkg::ST_IDLE, "read did not finish in one cycle")
  `TTCB_ASSERT_IMPLIES(a_cursor_range, clk, rst, 1'b1, int'(cur_col) < ttcb_pkg::COLS && int'(cur_row) < ttcb_pkg::ROWS, "cursor left the screen")

endmodule

/* design/text_terminal_char_buffer_unit.sv */
// ----------------------------------------------------------------------------
// Text terminal character buffer
// Character-cell text screen with a cursor, kept in a ring of rows.
// ----------------------------------------------------------------------------
// Each command word gives one result word. Put, move and the unused codes report
// as they are taken; read reports once the cell memory returns data, in the cycle
// after the address. Clear, a scroll, and a put that rolls the screen at the bottom
// row blank cells one per cycle through the single memory port: a clear or a
// scroll of ROWS or more rows blanks all ROWS*COLS cells (2048), a scroll of n
// rows n*COLS cells, and a rolling put COLS cells. After reset the same sweep
// blanks the whole memory before the first command word is taken. Up to two
// result words are held while the output is stalled.
module text_terminal_char_buffer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  ttcb_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ttcb_pkg::rsp_t rsp
);

  ttcb_pkg::mem_req_t          mem_req;
  logic [ttcb_pkg::CHAR_W-1:0] rd_data;
  logic                        push;
  ttcb_pkg::rsp_t              push_word;
  logic                        q_full;

  // Command decode, cursor and ring state.
  ttcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // Cell memory.
  ttcb_ram #(
    .ADDR_W (ttcb_pkg::ADDR_W),
    .DATA_W (ttcb_pkg::CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rd_data)
  );

  // Result queue on the output side.
  ttcb_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
